FILE: rtl/core/pcpc_pkg.sv
// Shared constants, types and helpers for the pixel context pattern counter.
package pcpc_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int CONTEXTS  = 16;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CTX_W  = $clog2(CONTEXTS);
   localparam int ROW_W  = 16;
   localparam int WREG_W = 12;
   localparam int CNT_W  = 32;
   localparam int CMD_W  = 2;
   localparam int PIX_W  = 8;
   localparam int CSR_DW = 16;
   localparam int CSR_AW = 1;

   // request tdata: gray [7:0], mask [15:8]
   localparam int REQ_DW = 2 * PIX_W;
   // response tdata: white [31:0], black [63:32], total [95:64]
   localparam int RSP_DW = 3 * CNT_W;

   localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [CSR_AW-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_AW-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam int WIDTH_MIN    = 2;
   localparam int HEIGHT_MIN   = 3;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   localparam logic [PIX_W-1:0] WHITE_THRESH = 8'd127;
   localparam logic [PIX_W-1:0] MASK_FULL    = 8'd255;

   // Line store entry bits, one 3-bit entry per row slot
   localparam int LS_WHITE = 0;
   localparam int LS_FULL  = 1;
   localparam int LS_NZ    = 2;
   localparam int LS_EW    = 3;
   localparam int SLOTS    = 3;
   localparam int LS_WW    = SLOTS * LS_EW;

   localparam logic [CNT_W-1:0] CNT_SAT = '1;

   typedef struct packed {
      logic             pix_load;   // capture gray/mask of an accepted pixel
      logic             rd_next;    // line store read at column + 1
      logic             word_latch; // hold the column word
      logic             ctx_step;   // decide context, write line store, advance
      logic             cnt_update; // bump the selected counter
      logic             cnt_clear;  // zero counter entry idx and the total
      logic             rep_load;   // load the response register
      logic [CTX_W-1:0] idx;
   } dp_cmd_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_SAT) ? v : v + CNT_W'(1);
   endfunction

endpackage

FILE: rtl/core/pcpc_datapath.sv
// Datapath: frame position, three-row line store, context counters, response register.
module pcpc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [pcpc_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [pcpc_pkg::CSR_DW-1:0]   csr_wdata,
   input  logic [pcpc_pkg::REQ_DW-1:0]   req_tdata,
   input  pcpc_pkg::dp_cmd_type          cmd,
   output logic                          eligible,
   output logic [pcpc_pkg::CTX_W-1:0]    rsp_ctx,
   output logic [pcpc_pkg::CNT_W-1:0]    rsp_white,
   output logic [pcpc_pkg::CNT_W-1:0]    rsp_black,
   output logic [pcpc_pkg::CNT_W-1:0]    rsp_total,
   output logic                          rsp_last
);
   import pcpc_pkg::*;

   localparam int EW = (COL_W + 1 > WREG_W) ? COL_W + 1 : WREG_W;

   function automatic logic [LS_EW-1:0] ls_field(input logic [LS_WW-1:0] w,
                                                 input logic [1:0] s);
      ls_field = w[s*LS_EW +: LS_EW];
   endfunction

   logic [COL_W:0]     width_eff_ff, width_eff_in;
   logic [ROW_W-1:0]   height_eff_ff, height_eff_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [1:0]         slot_ff, slot_in;
   logic [LS_EW-1:0]   cur_ff;
   logic [LS_WW-1:0]   word_c_ff;
   logic [LS_WW-1:0]   ls_rd_ff;
   logic [CTX_W-1:0]   ctx_ff;
   logic               ctr_white_ff;
   logic [2*CNT_W-1:0] cnt_rd_ff;
   logic [CNT_W-1:0]   total_ff, total_in;

   logic [LS_WW-1:0]   line_mem [MAX_WIDTH];
   logic [2*CNT_W-1:0] cnt_mem [CONTEXTS];

   logic [EW-1:0]      wr_width;
   logic [COL_W:0]     col_plus1;
   logic [ROW_W:0]     row_plus1;
   logic               col_last, row_last;
   logic [1:0]         slot_prev1, slot_prev2;
   logic [LS_EW-1:0]   ctr, up, ul, lf;
   logic [CTX_W-1:0]   ctx_comb;
   logic [COL_W-1:0]   ls_rd_addr;
   logic [LS_WW-1:0]   ls_wr_word;
   logic [CTX_W-1:0]   cnt_rd_addr;
   logic [CNT_W-1:0]   upd_white, upd_black;

   assign wr_width   = EW'(csr_wdata[WREG_W-1:0]);
   assign col_plus1  = {1'b0, col_ff} + (COL_W+1)'(1);
   assign row_plus1  = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign col_last   = col_plus1 >= width_eff_ff;
   assign row_last   = row_plus1 >= {1'b0, height_eff_ff};
   assign slot_prev1 = (slot_ff == 2'd0) ? 2'd2 : slot_ff - 2'd1;
   assign slot_prev2 = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;

   // column c+1 word in ls_rd_ff, column c word in word_c_ff
   assign ctr = ls_field(ls_rd_ff, slot_prev1);
   assign up  = ls_field(ls_rd_ff, slot_prev2);
   assign lf  = ls_field(word_c_ff, slot_prev1);
   assign ul  = ls_field(word_c_ff, slot_prev2);

   assign eligible = (row_ff >= ROW_W'(2)) && !col_last && ctr[LS_FULL] &&
                     ul[LS_NZ] && up[LS_NZ] && lf[LS_NZ] && cur_ff[LS_NZ];
   assign ctx_comb = {cur_ff[LS_WHITE], lf[LS_WHITE], up[LS_WHITE], ul[LS_WHITE]};

   assign ls_rd_addr  = cmd.rd_next ? col_plus1[COL_W-1:0] : col_ff;
   assign cnt_rd_addr = cmd.ctx_step ? ctx_comb : cmd.idx;

   always_comb begin
      ls_wr_word = word_c_ff;
      ls_wr_word[slot_ff*LS_EW +: LS_EW] = cur_ff;
   end

   always_comb begin
      upd_white = cnt_rd_ff[CNT_W-1:0];
      upd_black = cnt_rd_ff[2*CNT_W-1:CNT_W];
      if (ctr_white_ff) begin
         upd_white = sat_inc(cnt_rd_ff[CNT_W-1:0]);
      end else begin
         upd_black = sat_inc(cnt_rd_ff[2*CNT_W-1:CNT_W]);
      end
   end

   // Frame geometry and position
   always_comb begin
      width_eff_in  = width_eff_ff;
      height_eff_in = height_eff_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      slot_in       = slot_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            REG_IMAGE_WIDTH: begin
               if (wr_width < EW'(WIDTH_MIN)) begin
                  width_eff_in = (COL_W+1)'(WIDTH_MIN);
               end else if (wr_width > EW'(MAX_WIDTH)) begin
                  width_eff_in = (COL_W+1)'(MAX_WIDTH);
               end else begin
                  width_eff_in = wr_width[COL_W:0];
               end
            end
            REG_IMAGE_HEIGHT: begin
               height_eff_in = (csr_wdata < CSR_DW'(HEIGHT_MIN)) ?
                               ROW_W'(HEIGHT_MIN) : csr_wdata[ROW_W-1:0];
            end
            default: begin
            end
         endcase
         col_in  = '0;
         row_in  = '0;
         slot_in = 2'd0;
      end else if (cmd.ctx_step) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in  = '0;
               slot_in = 2'd0;
            end else begin
               row_in  = row_plus1[ROW_W-1:0];
               slot_in = slot_prev2;
            end
         end else begin
            col_in = col_plus1[COL_W-1:0];
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.cnt_clear) begin
         total_in = '0;
      end else if (cmd.cnt_update) begin
         total_in = sat_inc(total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_eff_ff  <= (COL_W+1)'(WIDTH_RESET);
         height_eff_ff <= ROW_W'(HEIGHT_RESET);
         col_ff        <= '0;
         row_ff        <= '0;
         slot_ff       <= 2'd0;
         total_ff      <= '0;
      end else begin
         width_eff_ff  <= width_eff_in;
         height_eff_ff <= height_eff_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         slot_ff       <= slot_in;
         total_ff      <= total_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.pix_load) begin
         cur_ff[LS_WHITE] <= req_tdata[PIX_W-1:0] > WHITE_THRESH;
         cur_ff[LS_FULL]  <= req_tdata[2*PIX_W-1:PIX_W] == MASK_FULL;
         cur_ff[LS_NZ]    <= req_tdata[2*PIX_W-1:PIX_W] != '0;
      end
      if (cmd.word_latch) begin
         word_c_ff <= ls_rd_ff;
      end
      if (cmd.ctx_step) begin
         ctx_ff       <= ctx_comb;
         ctr_white_ff <= ctr[LS_WHITE];
      end
      if (cmd.rep_load) begin
         rsp_ctx   <= cmd.idx;
         rsp_white <= cnt_rd_ff[CNT_W-1:0];
         rsp_black <= cnt_rd_ff[2*CNT_W-1:CNT_W];
         rsp_total <= total_ff;
         rsp_last  <= cmd.idx == CTX_W'(CONTEXTS - 1);
      end
   end

   // Line store: one word per column, three row slots per word
   always_ff @(posedge clock) begin
      ls_rd_ff <= line_mem[ls_rd_addr];
      if (cmd.ctx_step) begin
         line_mem[col_ff] <= ls_wr_word;
      end
   end

   // Counter store: {black, white} per context
   always_ff @(posedge clock) begin
      cnt_rd_ff <= cnt_mem[cnt_rd_addr];
      if (cmd.cnt_clear) begin
         cnt_mem[cmd.idx] <= '0;
      end else if (cmd.cnt_update) begin
         cnt_mem[ctx_ff] <= {upd_black, upd_white};
      end
   end

endmodule

FILE: rtl/core/pcpc_ctrl.sv
// Controller: request decode and sequencing of pixel, report and clear work.
module pcpc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic [pcpc_pkg::CMD_W-1:0]  req_tuser,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        eligible,
   output pcpc_pkg::dp_cmd_type        cmd
);
   import pcpc_pkg::*;

   localparam logic [2:0] S_CLR      = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_RD1      = 3'd2;
   localparam logic [2:0] S_CTX      = 3'd3;
   localparam logic [2:0] S_CNT      = 3'd4;
   localparam logic [2:0] S_REP_RD   = 3'd5;
   localparam logic [2:0] S_REP_LD   = 3'd6;
   localparam logic [2:0] S_REP_WAIT = 3'd7;

   localparam logic [CTX_W-1:0] IDX_LAST = CTX_W'(CONTEXTS - 1);

   logic [2:0]       state_ff, state_in;
   logic [CTX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      cmd            = '0;
      cmd.idx        = idx_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.cnt_clear = 1'b1;
            if (idx_ff == IDX_LAST) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + CTX_W'(1);
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_tuser)
                  CMD_PIXEL: begin
                     cmd.pix_load = 1'b1;
                     state_in     = S_RD1;
                  end
                  CMD_REPORT: begin
                     idx_in   = '0;
                     state_in = S_REP_RD;
                  end
                  CMD_CLEAR: begin
                     idx_in   = '0;
                     state_in = S_CLR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD1: begin
            cmd.rd_next    = 1'b1;
            cmd.word_latch = 1'b1;
            state_in       = S_CTX;
         end
         S_CTX: begin
            cmd.ctx_step = 1'b1;
            state_in     = eligible ? S_CNT : S_IDLE;
         end
         S_CNT: begin
            cmd.cnt_update = 1'b1;
            state_in       = S_IDLE;
         end
         S_REP_RD: begin
            state_in = S_REP_LD;
         end
         S_REP_LD: begin
            cmd.rep_load = 1'b1;
            state_in     = S_REP_WAIT;
         end
         S_REP_WAIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (idx_ff == IDX_LAST) begin
                  idx_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CTX_W'(1);
                  state_in = S_REP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   a_cnt_after_ctx: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CNT |-> $past(state_ff) == S_CTX)
      else $error("counter update without a context decision");

   a_report_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && idx_ff == IDX_LAST) |=> state_ff == S_IDLE)
      else $error("report did not end after the last context");

   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR && idx_ff == IDX_LAST) |=> state_ff == S_IDLE)
      else $error("clear pass did not end");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.cnt_clear && cmd.cnt_update))
      else $error("counter clear and update collide");

endmodule

FILE: rtl/core/pixel_context_pattern_counter.sv
// Top level of the pixel context pattern counter.
//
// Usage:
//  - req_* carries one request per handshake: tuser is the command (pixel, report,
//    clear), tdata the gray and mask bytes of a pixel. Pixels arrive in raster order.
//  - For each interior pixel with a full mask and nonzero neighbor masks, the 4-bit
//    context of its up-left, up, left and down-left neighbors selects a white or black
//    counter, and the total is bumped too. Counters saturate and span frames.
//  - A report request returns 16 responses on rsp_*, context 0 first, tlast on the
//    sixteenth. A clear request zeroes all counters.
//  - csr_* writes image_width (index 0) or image_height (index 1) and restarts the
//    frame; only write while the block is idle.
// Timing:
//  - A pixel takes two line store reads (column c and c+1 of the store, which has a
//    single read port), the context decision and, when it is counted, a
//    read-modify-write of the counter store.
//  - A clear is the request cycle, then one counter entry per cycle.
//  - A report is the request cycle, then per response a counter read, an rsp_* load
//    and any rsp_tready stall; req_tready is low until the sixteenth response is taken.
//  - After reset the block runs a clear pass over all 16 counters with req_tready low.
module pixel_context_pattern_counter (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write port
   input  logic                          csr_wen,
   input  logic [pcpc_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [pcpc_pkg::CSR_DW-1:0]   csr_wdata,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pcpc_pkg::REQ_DW-1:0]   req_tdata,  // gray [7:0], mask [15:8]
   input  logic [pcpc_pkg::CMD_W-1:0]    req_tuser,  // cmd [1:0]
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pcpc_pkg::RSP_DW-1:0]   rsp_tdata,  // white [31:0], black [63:32],
                                                     // total [95:64]
   output logic [pcpc_pkg::CTX_W-1:0]    rsp_tuser,  // context_res [3:0]
   output logic                          rsp_tlast
);
   import pcpc_pkg::*;

   dp_cmd_type       dp_cmd;
   logic             eligible;
   logic [CNT_W-1:0] rsp_white, rsp_black, rsp_total;

   pcpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .eligible   (eligible),
      .cmd        (dp_cmd)
   );

   pcpc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (dp_cmd),
      .eligible  (eligible),
      .rsp_ctx   (rsp_tuser),
      .rsp_white (rsp_white),
      .rsp_black (rsp_black),
      .rsp_total (rsp_total),
      .rsp_last  (rsp_tlast)
   );

   // response payload packing, lowest field first
   assign rsp_tdata = {rsp_total, rsp_black, rsp_white};

endmodule

FILE: tb/tb_pixel_context_pattern_counter.sv
// Self-checking testbench for the pixel context pattern counter: directed and random requests.
`timescale 1ns / 100ps

module tb_pixel_context_pattern_counter;

   // ---------------------------------------------------------------------------------
   // Constants
   // ---------------------------------------------------------------------------------
   localparam int WIDEST        = pcpc_pkg::MAX_WIDTH;
   localparam int NCTX          = pcpc_pkg::CONTEXTS;
   localparam int MIN_W         = 2;
   localparam int MIN_H         = 3;
   localparam int SETTLE_CYCLES = 24;    // longest silent job is a clear pass
   localparam int RSP_HOLD      = 400;   // long receiver stall, fills the block
   localparam int MAX_PRINTS    = 60;

   localparam logic [pcpc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [7:0] GRAY_WHITE_ABOVE = 8'd127;
   localparam logic [7:0] MASK_INSIDE      = 8'd255;

   // bits of one line entry
   localparam int PX_WHITE = 0;
   localparam int PX_FULL  = 1;
   localparam int PX_NZ    = 2;

   typedef struct packed {
      logic [pcpc_pkg::CTX_W-1:0] ctx;
      logic [31:0]                white;
      logic [31:0]                black;
      logic [31:0]                total;
      logic                       last;
   } context_count_type;

   // ---------------------------------------------------------------------------------
   // DUT signals
   // ---------------------------------------------------------------------------------
   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_wen;
   logic [pcpc_pkg::CSR_AW-1:0]   csr_addr;
   logic [pcpc_pkg::CSR_DW-1:0]   csr_wdata;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [pcpc_pkg::REQ_DW-1:0]   req_tdata;   // gray [7:0], mask [15:8]
   logic [pcpc_pkg::CMD_W-1:0]    req_tuser;   // cmd [1:0]
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [pcpc_pkg::RSP_DW-1:0]   rsp_tdata;   // white [31:0], black [63:32], total [95:64]
   logic [pcpc_pkg::CTX_W-1:0]    rsp_tuser;   // context_res [3:0]
   logic                          rsp_tlast;

   pixel_context_pattern_counter u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Predictor state: frame size, raster position, three-row line memory, counters
   // ---------------------------------------------------------------------------------
   logic [11:0]       width_reg;
   logic [15:0]       height_reg;
   int unsigned       col_pos;
   int unsigned       row_pos;
   logic [2:0]        line_mem [3][WIDEST];
   logic [31:0]       white_cnt [NCTX];
   logic [31:0]       black_cnt [NCTX];
   logic [31:0]       total_cnt;
   context_count_type pending_counts [$];   // report responses still owed by the block

   int mismatch_count = 0;
   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int hold_kicks     = 0;   // bumped by a test to ask for one long stall
   int holds_served   = 0;
   int hold_left      = 0;

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (&v) ? v : v + 32'd1;
   endfunction

   function void clear_counts();
      for (int i = 0; i < NCTX; i++) begin
         white_cnt[i] = '0;
         black_cnt[i] = '0;
      end
      total_cnt = '0;
   endfunction

   // One pixel in raster order. The centre one row up and one column right is
   // decided now, since the pixel just arriving is its down-left neighbor.
   function void model_pixel(input logic [7:0] gray, input logic [7:0] mask);
      int unsigned w, h, r, c;
      logic [2:0]  cur, ctr, ul, up, lf;
      logic [3:0]  ctx;
      w = (width_reg < MIN_W) ? MIN_W : ((width_reg > WIDEST) ? WIDEST : width_reg);
      h = (height_reg < MIN_H) ? MIN_H : height_reg;
      r = row_pos;
      c = col_pos;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      cur = {mask != 8'd0, mask == MASK_INSIDE, gray > GRAY_WHITE_ABOVE};
      if (r >= 2 && c + 1 < w) begin
         ctr = line_mem[(r - 1) % 3][c + 1];
         ul  = line_mem[(r - 2) % 3][c];
         up  = line_mem[(r - 2) % 3][c + 1];
         lf  = line_mem[(r - 1) % 3][c];
         if (ctr[PX_FULL] && ul[PX_NZ] && up[PX_NZ] && lf[PX_NZ] && cur[PX_NZ]) begin
            ctx = {cur[PX_WHITE], lf[PX_WHITE], up[PX_WHITE], ul[PX_WHITE]};
            if (ctr[PX_WHITE])
               white_cnt[ctx] = bump(white_cnt[ctx]);
            else
               black_cnt[ctx] = bump(black_cnt[ctx]);
            total_cnt = bump(total_cnt);
         end
      end
      line_mem[r % 3][c] = cur;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   function void predict_request(input logic [1:0] cmd, input logic [7:0] gray,
                                 input logic [7:0] mask);
      context_count_type item;
      case (cmd)
         pcpc_pkg::CMD_PIXEL: begin
            model_pixel(gray, mask);
         end
         pcpc_pkg::CMD_REPORT: begin
            for (int i = 0; i < NCTX; i++) begin
               item.ctx   = i[pcpc_pkg::CTX_W-1:0];
               item.white = white_cnt[i];
               item.black = black_cnt[i];
               item.total = total_cnt;
               item.last  = (i == NCTX - 1);
               pending_counts = {pending_counts, item};
            end
         end
         pcpc_pkg::CMD_CLEAR: begin
            clear_counts();   // position is kept
         end
         default: ;           // unused command: dropped, nothing changes
      endcase
   endfunction

   function void model_csr(input logic [pcpc_pkg::CSR_AW-1:0] addr,
                           input logic [pcpc_pkg::CSR_DW-1:0] data);
      if (addr == pcpc_pkg::REG_IMAGE_WIDTH)
         width_reg = data[11:0];
      else
         height_reg = data;
      col_pos = 0;   // any write restarts the frame
      row_pos = 0;
   endfunction

   // ---------------------------------------------------------------------------------
   // Mismatch report: one line each, printing capped, all counted
   // ---------------------------------------------------------------------------------
   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------------------
   // Response checker: every accepted response against the oldest expectation
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      context_count_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_counts.size() == 0) begin
            flag_mismatch($sformatf("response ctx %0d with none expected", rsp_tuser));
         end else begin
            want = pending_counts.pop_front();
            if (rsp_tuser !== want.ctx)
               flag_mismatch($sformatf("ctx got %0d want %0d", rsp_tuser, want.ctx));
            if (rsp_tdata[31:0] !== want.white)
               flag_mismatch($sformatf("ctx %0d white got %0d want %0d",
                                       want.ctx, rsp_tdata[31:0], want.white));
            if (rsp_tdata[63:32] !== want.black)
               flag_mismatch($sformatf("ctx %0d black got %0d want %0d",
                                       want.ctx, rsp_tdata[63:32], want.black));
            if (rsp_tdata[95:64] !== want.total)
               flag_mismatch($sformatf("ctx %0d total got %0d want %0d",
                                       want.ctx, rsp_tdata[95:64], want.total));
            if (rsp_tlast !== want.last)
               flag_mismatch($sformatf("ctx %0d last got %b want %b",
                                       want.ctx, rsp_tlast, want.last));
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver: random stalls, plus a long counted hold whenever a test asks for one
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != hold_kicks) begin
         rsp_tready   <= 1'b0;
         hold_left    <= RSP_HOLD - 1;
         holds_served <= hold_kicks;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------------
   // tvalid stays high between back-to-back requests; it only drops while idling
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] gray,
                               input logic [7:0] mask);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {mask, gray};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(cmd, gray, mask);
   endtask

   task automatic send_pixel(input logic [7:0] gray, input logic [7:0] mask);
      send_request(pcpc_pkg::CMD_PIXEL, gray, mask);
   endtask

   // stop sending, let every owed response drain, then let silent work finish
   task automatic settle_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers, back to back; only called with the block settled
   task automatic set_frame(input logic [15:0] width_data, input logic [15:0] height_data);
      csr_wen   <= 1'b1;
      csr_addr  <= pcpc_pkg::REG_IMAGE_WIDTH;
      csr_wdata <= width_data;
      @(posedge clock);
      model_csr(pcpc_pkg::REG_IMAGE_WIDTH, width_data);
      csr_addr  <= pcpc_pkg::REG_IMAGE_HEIGHT;
      csr_wdata <= height_data;
      @(posedge clock);
      model_csr(pcpc_pkg::REG_IMAGE_HEIGHT, height_data);
      csr_wen   <= 1'b0;
   endtask

   // mostly full masks so interior pixels get counted; some holes and partial masks
   task automatic send_random_pixel(input int full_pct);
      logic [7:0] mask;
      if ($urandom_range(99) < full_pct)
         mask = MASK_INSIDE;
      else if ($urandom_range(1) != 0)
         mask = 8'($urandom_range(255));
      else
         mask = 8'd0;
      send_pixel(8'($urandom_range(255)), mask);
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------
   // counters come out of the reset clearing pass as zero
   task automatic test_reset_counts();
      send_request(pcpc_pkg::CMD_REPORT, 8'd0, 8'd0);
      settle_block();
   endtask

   // Width 1 and height 0 both clamp to the smallest 2x3 frame, whose only centre
   // is row 1, column 1. Three frames: counted with partial neighbor masks, centre
   // mask not full, up neighbor masked out. The frame wraps between them.
   task automatic test_smallest_frames();
      logic [7:0] grays [18];
      logic [7:0] masks [18];
      grays = '{8'd255, 8'd128, 8'd127, 8'd200, 8'd0,   8'd90,
                8'd0,   8'd255, 8'd255, 8'd40,  8'd255, 8'd17,
                8'd130, 8'd3,   8'd250, 8'd100, 8'd129, 8'd255};
      masks = '{8'd1,   8'd254, 8'd255, 8'd255, 8'd1,   8'd0,
                8'd255, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255,
                8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255};
      set_frame(16'h0001, 16'h0000);
      for (int i = 0; i < 18; i++)
         send_pixel(grays[i], masks[i]);
      send_request(pcpc_pkg::CMD_REPORT, 8'd0, 8'd0);
      settle_block();
   endtask

   // unused command is dropped, clear zeroes everything, report shows it
   task automatic test_commands();
      send_request(CMD_UNUSED, 8'hFF, 8'hFF);
      send_request(pcpc_pkg::CMD_CLEAR, 8'd0, 8'd0);
      send_request(pcpc_pkg::CMD_REPORT, 8'd0, 8'd0);
      settle_block();
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so the
   // report backs up and req_tready drops; then the sender waits for a full drain.
   task automatic test_backpressure();
      set_frame(16'h0003, 16'h0004);
      hold_kicks <= hold_kicks + 1;
      send_request(pcpc_pkg::CMD_REPORT, 8'd0, 8'd0);
      repeat (6) send_random_pixel(90);
      send_request(pcpc_pkg::CMD_REPORT, 8'd0, 8'd0);
      repeat (4) send_random_pixel(90);
      settle_block();
      repeat (6) send_random_pixel(90);
      send_request(pcpc_pkg::CMD_REPORT, 8'd0, 8'd0);
      settle_block();
   endtask

   // Random frame size (mostly small, sometimes the limits), then a stream of mostly
   // pixels with the odd report, clear or unused command, closed by a report.
   task automatic run_random_phase(input int count);
      logic [11:0] w;
      logic [15:0] h;
      int          sent;
      int          pick;
      case ($urandom_range(9))
         8:       w = 12'(WIDEST);
         9:       w = 12'hFFF;
         default: w = 12'($urandom_range(7));
      endcase
      h = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(8));
      // upper bits of a width write are dropped by the register
      set_frame({4'($urandom_range(15)), w}, h);
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 84) begin
            send_random_pixel(75);
            sent++;
         end else if (pick < 91) begin
            send_request(pcpc_pkg::CMD_REPORT, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            sent++;
         end else if (pick < 96) begin
            send_request(pcpc_pkg::CMD_CLEAR, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            sent++;
         end else begin
            send_request(CMD_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
         end
      end
      send_request(pcpc_pkg::CMD_REPORT, 8'd0, 8'd0);
      settle_block();
   endtask

   // Width register all ones clamps to the widest row; a short run stays inside
   // row zero, so nothing new is counted and the report repeats the old counts.
   task automatic test_widest_rows();
      set_frame(16'hFFFF, 16'(MIN_H + $urandom_range(2)));
      repeat (8) send_random_pixel(97);
      send_request(pcpc_pkg::CMD_REPORT, 8'd0, 8'd0);
      settle_block();
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      csr_wen    <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= pcpc_pkg::CMD_PIXEL;
      width_reg  = 12'(pcpc_pkg::WIDTH_RESET);
      height_reg = 16'(pcpc_pkg::HEIGHT_RESET);
      col_pos    = 0;
      row_pos    = 0;
      clear_counts();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sender idles often, receiver more so
      req_idle_pct = 35;
      rsp_idle_pct = 59;
      test_reset_counts();
      test_smallest_frames();
      test_commands();
      run_random_phase(20);
      test_backpressure();

      // roles swapped
      req_idle_pct = 59;
      rsp_idle_pct = 35;
      run_random_phase(20);

      // full rate both ways
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random_phase(20);
      test_widest_rows();

      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
